// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the shower feature block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`define SDSF_ASSERT_DELAY2(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// File: rtl/sdsf_pkg.sv
// Package with the types, codes and constants of the shower feature block.
package sdsf_pkg;

   localparam int NUM_LAYERS_DEF      = 48;
   localparam int COUNT_BITS_DEF      = 12;

   localparam int OUT_CNT_BITS        = 12;
   localparam int LAYER_FIELD_W       = 6;
   localparam int LAYERS_HIT_OUT_BITS = 7;
   localparam int ENERGY_W            = 40;

   localparam int ACC_W               = 96;
   localparam int OPND_W              = 64;
   localparam int COEF_A_W            = 16;
   localparam int COEF_B_W            = 24;
   localparam int COEF_C_W            = 24;
   localparam int COEF_B_LSB          = 16;
   localparam int COEF_C_LSB          = 40;
   localparam int B_SHIFT             = 8;
   localparam int A_SHIFT             = 16;
   localparam int ROUND_SHIFT         = 16;
   localparam int NUM_THR             = 3;

   localparam int REQ_TDATA_W         = 8;
   localparam int REQ_THR_LSB         = 6;
   localparam int THR_CODE_W          = 2;
   localparam int RSP_TDATA_W         = 136;
   localparam int RSP_PAD_W           = 5;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 64;

   localparam logic FUNC_HIT    = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   localparam logic [THR_CODE_W-1:0] THR_1 = 2'd1;
   localparam logic [THR_CODE_W-1:0] THR_2 = 2'd2;
   localparam logic [THR_CODE_W-1:0] THR_3 = 2'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CALIB_ENABLE = 2'd0,
      CSR_THR1_COEFFS  = 2'd1,
      CSR_THR2_COEFFS  = 2'd2,
      CSR_THR3_COEFFS  = 2'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HIT_WR,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_CALC,
      ST_ROUND,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } state_type;

   typedef enum logic [1:0] {
      MAC_IDLE,
      MAC_LOAD,
      MAC_ADD_LO,
      MAC_ADD_HI
   } mac_op_type;

   typedef enum logic [1:0] {
      PASS_CN,
      PASS_VN,
      PASS_PS
   } pass_type;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } hist_ctl_type;

endpackage

// File: rtl/sdsf_mac.sv
// Shared signed multiply-accumulate unit that works a 64-bit operand in two 32-bit halves.
module sdsf_mac #(
   parameter int MULT_BITS = sdsf_pkg::COUNT_BITS_DEF + 2
) (
   input  logic                               clock,
   input  sdsf_pkg::mac_op_type               op,
   input  logic signed [sdsf_pkg::ACC_W-1:0]  init,
   input  logic signed [sdsf_pkg::OPND_W-1:0] operand,
   input  logic        [MULT_BITS-1:0]        mult,
   output logic signed [sdsf_pkg::ACC_W-1:0]  acc
);
   import sdsf_pkg::*;

   localparam int CHUNK_W = OPND_W / 2;
   localparam int PROD_W  = CHUNK_W + 1 + MULT_BITS + 1;

   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [CHUNK_W:0]   chunk_lo, chunk_hi, chunk_sel;
   logic signed [MULT_BITS:0] mult_s;

   assign chunk_lo  = $signed({1'b0, operand[CHUNK_W-1:0]});
   assign chunk_hi  = $signed({operand[OPND_W-1], operand[OPND_W-1:CHUNK_W]});
   assign chunk_sel = (op == MAC_ADD_LO) ? chunk_hi : chunk_lo;
   assign mult_s    = $signed({1'b0, mult});

   always_comb begin
      acc_in  = acc_ff;
      prod_in = prod_ff;
      case (op)
         MAC_LOAD: begin
            acc_in  = init;
            prod_in = chunk_sel * mult_s;
         end
         MAC_ADD_LO: begin
            acc_in  = acc_ff + ACC_W'(prod_ff);
            prod_in = chunk_sel * mult_s;
         end
         MAC_ADD_HI: begin
            acc_in = acc_ff + (ACC_W'(prod_ff) <<< CHUNK_W);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign acc = acc_ff;

endmodule

// File: rtl/sdsf_hist.sv
// Layer hit histogram memory with a valid bit per entry and a registered read port.
module sdsf_hist #(
   parameter int NUM_LAYERS = sdsf_pkg::NUM_LAYERS_DEF,
   parameter int COUNT_BITS = sdsf_pkg::COUNT_BITS_DEF,
   parameter int LAYER_AW   = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sdsf_pkg::hist_ctl_type ctl,
   input  logic [LAYER_AW-1:0]    rd_addr,
   input  logic [LAYER_AW-1:0]    wr_addr,
   input  logic [COUNT_BITS-1:0]  wr_data,
   output logic [COUNT_BITS-1:0]  rd_data
);
   import sdsf_pkg::*;

   logic [COUNT_BITS-1:0] mem [NUM_LAYERS];
   logic [NUM_LAYERS-1:0] valid_ff, valid_in;
   logic [COUNT_BITS-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/semidigital_shower_features_top.sv
// Top level of the semi-digital shower feature block: sequencer, counters and result port.
//
// Channel  Dir  One transfer carries
// req_     in   one hit (tuser 0) or one finish command (tuser 1)
// rsp_     out  one layer count with the shower summary, tlast on the last layer
// csr_     in   one register write, always taken
//
// A hit out of range is taken in ST_IDLE alone; one in range also passes ST_HIT_WR (memory
// read, write). A finish scans the layer memory (ST_SCAN, ST_SCAN_TAIL), runs the CN, VN and PS
// passes per threshold on the shared multiply-accumulate unit and rounds when calibration is
// on, then emits each result through ST_EMIT_RD and ST_EMIT_WAIT, holding while rsp_tready is
// low. Reset is synchronous; valid bits make the memory read as zero.
module semidigital_shower_features_top #(
   parameter int NUM_LAYERS = sdsf_pkg::NUM_LAYERS_DEF,
   parameter int COUNT_BITS = sdsf_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // hit_layer [5:0], hit_threshold [7:6]
   input  logic [sdsf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // layer_index, layer_hits, hits_thr1, hits_thr2, hits_thr3, layers_hit, max_layer,
   // hits_at_max, energy, dropped_hits, zero fill
   output logic [sdsf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   // energy_valid
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sdsf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sdsf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sdsf_pkg::*;

   localparam int LAYER_AW  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
   localparam int LH_W      = $clog2(NUM_LAYERS + 1);
   localparam int MULT_BITS = COUNT_BITS + 2;
   localparam logic [LAYER_AW-1:0] LAST_IDX = LAYER_AW'(NUM_LAYERS - 1);
   localparam logic [1:0] LAST_THR = 2'(NUM_THR - 1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (ROUND_SHIFT - 1));

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   state_type state_ff, state_in;

   logic                  calib_ff, calib_in;
   logic [OPND_W-1:0]     thr1_coeffs_ff, thr1_coeffs_in;
   logic [OPND_W-1:0]     thr2_coeffs_ff, thr2_coeffs_in;
   logic [OPND_W-1:0]     thr3_coeffs_ff, thr3_coeffs_in;

   logic [COUNT_BITS-1:0] thr1_ff, thr1_in, thr2_ff, thr2_in, thr3_ff, thr3_in;
   logic [COUNT_BITS-1:0] drop_ff, drop_in;

   logic [LAYER_AW-1:0]   layer_ff, layer_in;
   logic [LAYER_AW-1:0]   idx_ff, idx_in;
   logic [LAYER_AW-1:0]   tag_ff, tag_in;
   logic                  scan_vld_ff, scan_vld_in;
   logic [LH_W-1:0]       layers_hit_ff, layers_hit_in;
   logic [LAYER_AW-1:0]   max_l_ff, max_l_in;
   logic [COUNT_BITS-1:0] max_c_ff, max_c_in;

   logic [1:0]            k_ff, k_in;
   pass_type              kind_ff, kind_in;
   mac_op_type            phase_ff, phase_in;
   logic signed [OPND_W-1:0]   op_ff, op_in;
   logic signed [ACC_W-1:0]    s_ff, s_in;
   logic signed [ENERGY_W-1:0] energy_ff, energy_in;
   logic                  energy_valid_ff, energy_valid_in;

   hist_ctl_type          hist_ctl;
   logic [LAYER_AW-1:0]   rd_addr;
   logic [COUNT_BITS-1:0] rd_data;
   logic [COUNT_BITS-1:0] wr_data;

   mac_op_type                 mac_op;
   logic signed [ACC_W-1:0]    mac_init;
   logic signed [OPND_W-1:0]   mac_operand;
   logic [MULT_BITS-1:0]       mac_mult;
   logic signed [ACC_W-1:0]    mac_acc;

   logic [OPND_W-1:0]          coeff;
   logic [COUNT_BITS-1:0]      cnt_k;
   logic [MULT_BITS-1:0]       n_sum;
   logic signed [COEF_A_W-1:0] coef_a;
   logic signed [COEF_B_W-1:0] coef_b;
   logic signed [COEF_C_W-1:0] coef_c;

   logic [LAYER_FIELD_W-1:0]   req_layer;
   logic [THR_CODE_W-1:0]      req_thr;
   logic                       req_in_range;

   logic signed [ACC_W-1:0]    s_round;
   logic [ACC_W-ROUND_SHIFT-ENERGY_W:0] s_high;
   logic signed [ENERGY_W-1:0] energy_sat;

   assign req_layer    = req_tdata[LAYER_FIELD_W-1:0];
   assign req_thr      = req_tdata[REQ_THR_LSB +: THR_CODE_W];
   assign req_in_range = {1'b0, req_layer} < (LAYER_FIELD_W + 1)'(NUM_LAYERS);

   assign wr_data = sat_inc(rd_data);

   always_comb begin
      case (k_ff)
         2'd0: begin
            coeff = thr1_coeffs_ff;
            cnt_k = thr1_ff;
         end
         2'd1: begin
            coeff = thr2_coeffs_ff;
            cnt_k = thr2_ff;
         end
         default: begin
            coeff = thr3_coeffs_ff;
            cnt_k = thr3_ff;
         end
      endcase
   end

   assign coef_a = $signed(coeff[COEF_A_W-1:0]);
   assign coef_b = $signed(coeff[COEF_B_LSB +: COEF_B_W]);
   assign coef_c = $signed(coeff[COEF_C_LSB +: COEF_C_W]);
   assign n_sum  = MULT_BITS'(thr1_ff) + MULT_BITS'(thr2_ff) + MULT_BITS'(thr3_ff);

   always_comb begin
      case (kind_ff)
         PASS_CN: begin
            mac_init    = ACC_W'(coef_b) <<< B_SHIFT;
            mac_operand = OPND_W'(coef_c);
            mac_mult    = n_sum;
         end
         PASS_VN: begin
            mac_init    = ACC_W'(coef_a) <<< A_SHIFT;
            mac_operand = op_ff;
            mac_mult    = n_sum;
         end
         default: begin
            mac_init    = s_ff;
            mac_operand = op_ff;
            mac_mult    = MULT_BITS'(cnt_k);
         end
      endcase
   end

   assign s_round = s_ff + ROUND_HALF;
   assign s_high  = s_round[ACC_W-1:ROUND_SHIFT+ENERGY_W-1];

   always_comb begin
      if ((&s_high) || !(|s_high)) begin
         energy_sat = s_round[ROUND_SHIFT +: ENERGY_W];
      end else if (s_high[ACC_W-ROUND_SHIFT-ENERGY_W]) begin
         energy_sat = {1'b1, {(ENERGY_W - 1){1'b0}}};
      end else begin
         energy_sat = {1'b0, {(ENERGY_W - 1){1'b1}}};
      end
   end

   always_comb begin
      state_in        = state_ff;
      calib_in        = calib_ff;
      thr1_coeffs_in  = thr1_coeffs_ff;
      thr2_coeffs_in  = thr2_coeffs_ff;
      thr3_coeffs_in  = thr3_coeffs_ff;
      thr1_in         = thr1_ff;
      thr2_in         = thr2_ff;
      thr3_in         = thr3_ff;
      drop_in         = drop_ff;
      layer_in        = layer_ff;
      idx_in          = idx_ff;
      tag_in          = tag_ff;
      scan_vld_in     = scan_vld_ff;
      layers_hit_in   = layers_hit_ff;
      max_l_in        = max_l_ff;
      max_c_in        = max_c_ff;
      k_in            = k_ff;
      kind_in         = kind_ff;
      phase_in        = phase_ff;
      op_in           = op_ff;
      s_in            = s_ff;
      energy_in       = energy_ff;
      energy_valid_in = energy_valid_ff;
      hist_ctl        = '{wr_en: 1'b0, clear_all: 1'b0};
      mac_op          = MAC_IDLE;
      rd_addr         = idx_ff;
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_CALIB_ENABLE: calib_in       = csr_data[0];
            CSR_THR1_COEFFS:  thr1_coeffs_in = csr_data;
            CSR_THR2_COEFFS:  thr2_coeffs_in = csr_data;
            CSR_THR3_COEFFS:  thr3_coeffs_in = csr_data;
            default: begin
            end
         endcase
      end

      if (scan_vld_ff) begin
         if (rd_data != '0) begin
            layers_hit_in = layers_hit_ff + 1'b1;
         end
         if (rd_data > max_c_ff) begin
            max_c_in = rd_data;
            max_l_in = tag_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = req_layer[LAYER_AW-1:0];
            if (req_tvalid) begin
               if (req_tuser == FUNC_HIT) begin
                  layer_in = req_layer[LAYER_AW-1:0];
                  if (req_in_range) begin
                     state_in = ST_HIT_WR;
                  end else begin
                     drop_in = sat_inc(drop_ff);
                  end
                  case (req_thr)
                     THR_1:   thr1_in = sat_inc(thr1_ff);
                     THR_2:   thr2_in = sat_inc(thr2_ff);
                     THR_3:   thr3_in = sat_inc(thr3_ff);
                     default: begin
                     end
                  endcase
               end else begin
                  idx_in          = '0;
                  layers_hit_in   = '0;
                  max_l_in        = '0;
                  max_c_in        = '0;
                  energy_in       = '0;
                  energy_valid_in = calib_ff;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_HIT_WR: begin
            hist_ctl.wr_en = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            tag_in      = idx_ff;
            scan_vld_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_SCAN_TAIL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN_TAIL: begin
            scan_vld_in = 1'b0;
            if (calib_ff) begin
               k_in     = '0;
               kind_in  = PASS_CN;
               phase_in = MAC_LOAD;
               s_in     = '0;
               state_in = ST_CALC;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_CALC: begin
            mac_op = phase_ff;
            case (phase_ff)
               MAC_LOAD:   phase_in = MAC_ADD_LO;
               MAC_ADD_LO: phase_in = MAC_ADD_HI;
               MAC_ADD_HI: phase_in = MAC_IDLE;
               default: begin
                  phase_in = MAC_LOAD;
                  case (kind_ff)
                     PASS_CN: begin
                        op_in   = mac_acc[OPND_W-1:0];
                        kind_in = PASS_VN;
                     end
                     PASS_VN: begin
                        op_in   = mac_acc[OPND_W-1:0];
                        kind_in = PASS_PS;
                     end
                     default: begin
                        s_in    = mac_acc;
                        kind_in = PASS_CN;
                        if (k_ff == LAST_THR) begin
                           state_in = ST_ROUND;
                        end else begin
                           k_in = k_ff + 1'b1;
                        end
                     end
                  endcase
               end
            endcase
         end
         ST_ROUND: begin
            energy_in = energy_sat;
            state_in  = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (idx_ff == LAST_IDX) begin
                  thr1_in            = '0;
                  thr2_in            = '0;
                  thr3_in            = '0;
                  drop_in            = '0;
                  hist_ctl.clear_all = 1'b1;
                  state_in           = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff       <= 1'b0;
         thr1_coeffs_ff <= '0;
         thr2_coeffs_ff <= '0;
         thr3_coeffs_ff <= '0;
         thr1_ff        <= '0;
         thr2_ff        <= '0;
         thr3_ff        <= '0;
         drop_ff        <= '0;
         idx_ff         <= '0;
         scan_vld_ff    <= 1'b0;
         k_ff           <= '0;
         kind_ff        <= PASS_CN;
         phase_ff       <= MAC_LOAD;
      end else begin
         calib_ff       <= calib_in;
         thr1_coeffs_ff <= thr1_coeffs_in;
         thr2_coeffs_ff <= thr2_coeffs_in;
         thr3_coeffs_ff <= thr3_coeffs_in;
         thr1_ff        <= thr1_in;
         thr2_ff        <= thr2_in;
         thr3_ff        <= thr3_in;
         drop_ff        <= drop_in;
         idx_ff         <= idx_in;
         scan_vld_ff    <= scan_vld_in;
         k_ff           <= k_in;
         kind_ff        <= kind_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff        <= layer_in;
      tag_ff          <= tag_in;
      layers_hit_ff   <= layers_hit_in;
      max_l_ff        <= max_l_in;
      max_c_ff        <= max_c_in;
      op_ff           <= op_in;
      s_ff            <= s_in;
      energy_ff       <= energy_in;
      energy_valid_ff <= energy_valid_in;
   end

   sdsf_hist #(
      .NUM_LAYERS (NUM_LAYERS),
      .COUNT_BITS (COUNT_BITS),
      .LAYER_AW   (LAYER_AW)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hist_ctl),
      .rd_addr (rd_addr),
      .wr_addr (layer_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   sdsf_mac #(
      .MULT_BITS (MULT_BITS)
   ) u_mac (
      .clock   (clock),
      .op      (mac_op),
      .init    (mac_init),
      .operand (mac_operand),
      .mult    (mac_mult),
      .acc     (mac_acc)
   );

   assign csr_ready = 1'b1;
   assign rsp_tlast = (idx_ff == LAST_IDX);
   assign rsp_tuser = energy_valid_ff;
   assign rsp_tdata = {
      {RSP_PAD_W{1'b0}},
      OUT_CNT_BITS'(drop_ff),
      energy_ff,
      OUT_CNT_BITS'(max_c_ff),
      LAYER_FIELD_W'(max_l_ff),
      LAYERS_HIT_OUT_BITS'(layers_hit_ff),
      OUT_CNT_BITS'(thr3_ff),
      OUT_CNT_BITS'(thr2_ff),
      OUT_CNT_BITS'(thr1_ff),
      OUT_CNT_BITS'(rd_data),
      LAYER_FIELD_W'(idx_ff)
   };

endmodule

// File: rtl/sdsf_checker.sv
// Port-level checker for the shower feature block, bound to its top level.
`include "assert_macros.svh"

module sdsf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sdsf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);
   import sdsf_pkg::*;

   logic req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   `SDSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "Stalled result changed")
   `SDSF_ASSERT_SAME(a_one_item, clock, reset, req_tready, !rsp_tvalid, "Input taken while results are pending")
   `SDSF_ASSERT_NEXT(a_finish_busy, clock, reset, req_xfer && (req_tuser == FUNC_FINISH), !req_tready, "Finish transfer did not start the result run")
   `SDSF_ASSERT_NEXT(a_last_idle, clock, reset, rsp_xfer && rsp_tlast, req_tready && !rsp_tvalid, "Block not idle after the last result")
   `SDSF_ASSERT_DELAY2(a_layer_step, clock, reset, rsp_xfer && !rsp_tlast, rsp_tvalid && (rsp_tdata[LAYER_FIELD_W-1:0] == $past(rsp_tdata[LAYER_FIELD_W-1:0], 2) + 1), "Layer index did not step by one")

endmodule

bind semidigital_shower_features_top sdsf_checker u_sdsf_checker (.*);

// File: tb/semidigital_shower_features_top_tb.sv
// Self-checking testbench for the semi-digital shower feature block, with its own prediction.
module semidigital_shower_features_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sdsf_pkg::*;

   localparam int          NUM_LAYERS   = NUM_LAYERS_DEF;
   localparam int unsigned COUNT_MAX    = (1 << COUNT_BITS_DEF) - 1;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned BURST_HITS   = 6;

   localparam logic [THR_CODE_W-1:0] THR_NONE = 2'd0;

   localparam logic signed [127:0] ENERGY_HI = 128'sh7F_FFFF_FFFF;
   localparam logic signed [127:0] ENERGY_LO = -ENERGY_HI - 1;

   localparam logic [63:0] COEF_MAX_POS = {24'h7F_FFFF, 24'h7F_FFFF, 16'h7FFF};
   localparam logic [63:0] COEF_MAX_NEG = {24'h80_0000, 24'h80_0000, 16'h8000};
   localparam logic [63:0] COEF_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic                      func;
      logic [LAYER_FIELD_W-1:0]  layer;
      logic [THR_CODE_W-1:0]     thr;
      int unsigned               gap;
   } shower_item_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]            pad;
      logic [OUT_CNT_BITS-1:0]         dropped_hits;
      logic [ENERGY_W-1:0]             energy;
      logic [OUT_CNT_BITS-1:0]         hits_at_max;
      logic [LAYER_FIELD_W-1:0]        max_layer;
      logic [LAYERS_HIT_OUT_BITS-1:0]  layers_hit;
      logic [OUT_CNT_BITS-1:0]         hits_thr3;
      logic [OUT_CNT_BITS-1:0]         hits_thr2;
      logic [OUT_CNT_BITS-1:0]         hits_thr1;
      logic [OUT_CNT_BITS-1:0]         layer_hits;
      logic [LAYER_FIELD_W-1:0]        layer_index;
   } rsp_word_type;

   typedef struct {
      rsp_word_type word;
      logic         is_last;
      logic         energy_valid;
   } layer_report_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   shower_item_type   hit_queue[$];
   layer_report_type  report_queue[$];
   shower_item_type   staged;
   logic           staged_ok    = 1'b0;
   int unsigned    gap_left     = 0;
   int unsigned    stall_left   = 0;
   logic           quiet        = 1'b0;
   int unsigned    queued_cnt   = 0;
   int unsigned    accepted_cnt = 0;
   int unsigned    mismatch_cnt = 0;
   int unsigned    cycle_cnt    = 0;

   int unsigned    layer_tally[NUM_LAYERS];
   int unsigned    thr_tally[NUM_THR];
   int unsigned    dropped_tally;
   logic           calib_on;
   logic [63:0]    coef[NUM_THR];

   semidigital_shower_features_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int unsigned bump(int unsigned v);
      return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
   endfunction

   function automatic logic [ENERGY_W-1:0] calibrated_energy();
      logic signed [127:0] a, b, c, n, cnt, p, acc, r;
      acc = '0;
      n = $signed(128'(thr_tally[0]) + 128'(thr_tally[1]) + 128'(thr_tally[2]));
      for (int k = 0; k < NUM_THR; k++) begin
         a   = {{(128 - COEF_A_W){coef[k][COEF_A_W-1]}}, coef[k][COEF_A_W-1:0]};
         b   = {{(128 - COEF_B_W){coef[k][COEF_C_LSB-1]}}, coef[k][COEF_C_LSB-1:COEF_B_LSB]};
         c   = {{(128 - COEF_C_W){coef[k][63]}}, coef[k][63:COEF_C_LSB]};
         cnt = $signed(128'(thr_tally[k]));
         p   = a * 65536 + b * n * 256 + c * n * n;
         acc = acc + cnt * p;
      end
      r = (acc + 32768) >>> ROUND_SHIFT;
      if (r > ENERGY_HI) return ENERGY_HI[ENERGY_W-1:0];
      if (r < ENERGY_LO) return ENERGY_LO[ENERGY_W-1:0];
      return r[ENERGY_W-1:0];
   endfunction

   task automatic clear_shower();
      foreach (layer_tally[i]) layer_tally[i] = 0;
      foreach (thr_tally[i]) thr_tally[i] = 0;
      dropped_tally = 0;
   endtask

   task automatic tally_hit(logic [LAYER_FIELD_W-1:0] layer, logic [THR_CODE_W-1:0] thr);
      if (layer < NUM_LAYERS) layer_tally[layer] = bump(layer_tally[layer]);
      else dropped_tally = bump(dropped_tally);
      case (thr)
         THR_1: thr_tally[0] = bump(thr_tally[0]);
         THR_2: thr_tally[1] = bump(thr_tally[1]);
         THR_3: thr_tally[2] = bump(thr_tally[2]);
         default: ;
      endcase
   endtask

   task automatic close_shower();
      layer_report_type rep;
      int unsigned   layers_hit, max_count, max_layer;
      logic [ENERGY_W-1:0] energy;
      layers_hit = 0;
      max_count  = 0;
      max_layer  = 0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
         if (layer_tally[i] != 0) layers_hit++;
         if (layer_tally[i] > max_count) begin
            max_count = layer_tally[i];
            max_layer = i;
         end
      end
      energy = calib_on ? calibrated_energy() : '0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
         rep.word              = '0;
         rep.word.layer_index  = LAYER_FIELD_W'(i);
         rep.word.layer_hits   = OUT_CNT_BITS'(layer_tally[i]);
         rep.word.hits_thr1    = OUT_CNT_BITS'(thr_tally[0]);
         rep.word.hits_thr2    = OUT_CNT_BITS'(thr_tally[1]);
         rep.word.hits_thr3    = OUT_CNT_BITS'(thr_tally[2]);
         rep.word.layers_hit   = LAYERS_HIT_OUT_BITS'(layers_hit);
         rep.word.max_layer    = LAYER_FIELD_W'(max_layer);
         rep.word.hits_at_max  = OUT_CNT_BITS'(max_count);
         rep.word.energy       = energy;
         rep.word.dropped_hits = OUT_CNT_BITS'(dropped_tally);
         rep.is_last           = (i == NUM_LAYERS - 1);
         rep.energy_valid      = calib_on;
         report_queue          = {report_queue, rep};
      end
      clear_shower();
   endtask

   always @(posedge clock) begin : shower_model
      if (reset) begin
         clear_shower();
         calib_on = 1'b0;
         foreach (coef[i]) coef[i] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               CSR_CALIB_ENABLE: calib_on = csr_data[0];
               CSR_THR1_COEFFS:  coef[0] = csr_data;
               CSR_THR2_COEFFS:  coef[1] = csr_data;
               CSR_THR3_COEFFS:  coef[2] = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            accepted_cnt++;
            if (req_tuser == FUNC_HIT)
               tally_hit(req_tdata[LAYER_FIELD_W-1:0], req_tdata[REQ_THR_LSB +: THR_CODE_W]);
            else
               close_shower();
         end
      end
   end

   always @(posedge clock) begin : hit_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         staged_ok = 1'b0;
         gap_left  = 0;
      end else if (!req_tvalid || req_tready) begin
         if (!staged_ok && hit_queue.size() != 0) begin
            staged    = hit_queue.pop_front();
            staged_ok = 1'b1;
            gap_left  = staged.gap;
         end
         if (staged_ok && gap_left == 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= staged.func;
            req_tdata  <= {staged.thr, staged.layer};
            staged_ok = 1'b0;
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left != 0) gap_left--;
         end
      end
   end

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_cnt++;
      end
   endtask

   always @(posedge clock) begin : report_monitor
      layer_report_type want;
      rsp_word_type     got;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (report_queue.size() == 0) begin
               $error("layer result transfer with no result expected");
               mismatch_cnt++;
            end else begin
               want = report_queue.pop_front();
               compare_field("layer_index", 64'(want.word.layer_index), 64'(got.layer_index));
               compare_field("layer_hits", 64'(want.word.layer_hits), 64'(got.layer_hits));
               compare_field("is_last", 64'(want.is_last), 64'(rsp_tlast));
               compare_field("hits_thr1", 64'(want.word.hits_thr1), 64'(got.hits_thr1));
               compare_field("hits_thr2", 64'(want.word.hits_thr2), 64'(got.hits_thr2));
               compare_field("hits_thr3", 64'(want.word.hits_thr3), 64'(got.hits_thr3));
               compare_field("layers_hit", 64'(want.word.layers_hit), 64'(got.layers_hit));
               compare_field("max_layer", 64'(want.word.max_layer), 64'(got.max_layer));
               compare_field("hits_at_max", 64'(want.word.hits_at_max), 64'(got.hits_at_max));
               compare_field("energy", 64'(want.word.energy), 64'(got.energy));
               compare_field("energy_valid", 64'(want.energy_valid), 64'(rsp_tuser));
               compare_field("dropped_hits", 64'(want.word.dropped_hits),
                             64'(got.dropped_hits));
            end
            stall_left = quiet ? 0 : $urandom_range(0, 8);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_item(logic func, logic [LAYER_FIELD_W-1:0] layer,
                             logic [THR_CODE_W-1:0] thr);
      shower_item_type it;
      it.func  = func;
      it.layer = layer;
      it.thr   = thr;
      it.gap   = quiet ? 0 : $urandom_range(0, 8);
      hit_queue = {hit_queue, it};
      queued_cnt++;
   endtask

   task automatic settle();
      while (accepted_cnt != queued_cnt || report_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(logic en, logic [63:0] c1, logic [63:0] c2, logic [63:0] c3);
      settle();
      @(posedge clock);
      write_reg(CSR_CALIB_ENABLE, {63'd0, en});
      write_reg(CSR_THR1_COEFFS, c1);
      write_reg(CSR_THR2_COEFFS, c2);
      write_reg(CSR_THR3_COEFFS, c3);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_coef();
      logic [63:0] w;
      if ($urandom_range(0, 2) == 0) begin
         w = {$urandom, $urandom};
      end else begin
         w[15:0]  = 16'($urandom);
         w[39:16] = 24'(int'($urandom_range(0, 8191)) - 4096);
         w[63:40] = 24'(int'($urandom_range(0, 511)) - 256);
      end
      return w;
   endfunction

   initial begin : stimulus
      int unsigned n_items, len;
      logic [LAYER_FIELD_W-1:0] layer;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Calibration off: drops, a tie for the busiest layer, ignored fields on finish.
      queue_item(FUNC_HIT, 6'd0, THR_NONE);
      queue_item(FUNC_HIT, 6'd47, THR_3);
      queue_item(FUNC_HIT, 6'd63, THR_1);
      queue_item(FUNC_HIT, 6'd48, THR_2);
      queue_item(FUNC_HIT, 6'd47, THR_3);
      queue_item(FUNC_HIT, 6'd9, THR_2);
      queue_item(FUNC_HIT, 6'd9, THR_1);
      queue_item(FUNC_HIT, 6'd21, THR_NONE);
      queue_item(FUNC_FINISH, 6'd63, THR_3);
      queue_item(FUNC_FINISH, 6'd0, THR_NONE);

      // Largest positive and negative coefficients on short showers.
      quiet = 1'b1;
      configure(1'b1, COEF_MAX_POS, COEF_MAX_POS, COEF_MAX_POS);
      for (int i = 0; i < BURST_HITS; i++) queue_item(FUNC_HIT, 6'd5, THR_1);
      for (int i = 0; i < BURST_HITS; i++) queue_item(FUNC_HIT, 6'd60, THR_2);
      for (int i = 0; i < BURST_HITS; i++) queue_item(FUNC_HIT, 6'd5, THR_3);
      queue_item(FUNC_FINISH, 6'd0, THR_NONE);

      configure(1'b1, COEF_MAX_NEG, COEF_MAX_NEG, COEF_MAX_NEG);
      for (int i = 0; i < BURST_HITS; i++) queue_item(FUNC_HIT, 6'd0, THR_1);
      queue_item(FUNC_HIT, 6'd47, THR_3);
      queue_item(FUNC_FINISH, 6'd0, THR_NONE);
      quiet = 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(1'b1, COEF_ONES, COEF_ONES, COEF_ONES);
            1: configure(1'b0, rand_coef(), rand_coef(), rand_coef());
            default: configure($urandom_range(0, 3) != 0, rand_coef(), rand_coef(),
                               rand_coef());
         endcase
         quiet = (ph == 3);
         n_items = 0;
         while (n_items < 28) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_item(1'($urandom), 6'($urandom), 2'($urandom));
               n_items++;
            end
            len = $urandom_range(0, 12);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 7) == 0) layer = 6'($urandom_range(48, 63));
               else layer = 6'($urandom_range(0, 47));
               queue_item(FUNC_HIT, layer, 2'($urandom));
            end
            queue_item(FUNC_FINISH, 6'($urandom), 2'($urandom));
            n_items += len + 1;
         end
         if ($urandom_range(0, 1) != 0)
            repeat ($urandom_range(1, 4)) queue_item(FUNC_HIT, 6'($urandom), 2'($urandom));
         quiet = 1'b0;
      end

      settle();
      if (mismatch_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
